// ===== design/sts_pkg.sv =====
// sts_pkg: shared types and character codes for the S-expression token splitter.
// Depends on nothing; used by the front, queue, back and top modules.

package sts_pkg;

	localparam int STS_MAX_RESULTS = 4;
	localparam int STS_FIFO_DEPTH  = 2;

	typedef enum logic [1:0] {
		KIND_CHAR    = 2'd0,
		KIND_END     = 2'd1,
		KIND_NEWLINE = 2'd2,
		KIND_TRUE    = 2'd3
	} kind_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_FF8   = 8'hFF;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_QUOTE = 8'h27;
	localparam logic [7:0] CH_LP    = 8'h28;
	localparam logic [7:0] CH_RP    = 8'h29;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_T     = 8'h74;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] ch;
	} res_t;

	typedef struct packed {
		res_t [STS_MAX_RESULTS-1:0] r;
		logic [1:0]                 last_idx;
	} bundle_t;

endpackage

// ===== design/sts_if.sv =====
// sts_if: valid/ready channel interfaces for text bytes in and token results out.
// Depends on nothing.

interface sts_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       end_of_text;

	modport source (output valid, ch, end_of_text, input ready);
	modport sink   (input valid, ch, end_of_text, output ready);
endinterface

interface sts_token_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] out_char;
	logic       last_of_run;

	modport source (output valid, kind, out_char, last_of_run, input ready);
	modport sink   (input valid, kind, out_char, last_of_run, output ready);
endinterface

// ===== design/sts_front.sv =====
// sts_front: accepts text bytes, tracks string/comment/token/hash flags and
// builds the bundle of up to four results per byte. Depends on sts_pkg, sts_if.

module sts_front import sts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	sts_text_if.sink    text,
	input  logic        full,
	output logic        push,
	output bundle_t     push_data
);

	logic    string_q, comment_q, open_q, hash_q;
	logic    so, co, to, ho;
	logic [2:0] n;
	bundle_t b;
	logic    accept;

	always_comb begin
		b  = '0;
		n  = '0;
		so = string_q;
		co = comment_q;
		to = open_q;
		ho = hash_q;
		if (text.end_of_text) begin
			if (ho) begin
				if (to) begin b.r[n[1:0]] = '{kind: KIND_END, ch: '0}; n = n + 3'd1; end
				b.r[n[1:0]] = '{kind: KIND_CHAR, ch: CH_HASH}; n = n + 3'd1;
				b.r[n[1:0]] = '{kind: KIND_END, ch: '0}; n = n + 3'd1;
				to = 1'b0;
			end
			if (to) begin b.r[n[1:0]] = '{kind: KIND_END, ch: '0}; n = n + 3'd1; end
			so = 1'b0;
			co = 1'b0;
			to = 1'b0;
			ho = 1'b0;
		end else if (co) begin
			if (text.ch == CH_NL) begin
				b.r[n[1:0]] = '{kind: KIND_NEWLINE, ch: '0}; n = n + 3'd1;
				co = 1'b0;
			end else if (text.ch == CH_NUL || text.ch == CH_FF8) begin
				co = 1'b0;
			end
		end else if (ho && text.ch == CH_T) begin
			ho = 1'b0;
			b.r[n[1:0]] = '{kind: KIND_TRUE, ch: '0}; n = n + 3'd1;
		end else begin
			if (ho) begin
				ho = 1'b0;
				if (to) begin b.r[n[1:0]] = '{kind: KIND_END, ch: '0}; n = n + 3'd1; end
				b.r[n[1:0]] = '{kind: KIND_CHAR, ch: CH_HASH}; n = n + 3'd1;
				b.r[n[1:0]] = '{kind: KIND_END, ch: '0}; n = n + 3'd1;
				to = 1'b0;
			end
			case (text.ch)
				CH_NL: begin
					if (to) begin b.r[n[1:0]] = '{kind: KIND_END, ch: '0}; n = n + 3'd1; end
					to = 1'b0;
					b.r[n[1:0]] = '{kind: KIND_NEWLINE, ch: '0}; n = n + 3'd1;
				end
				CH_CR, CH_FF, CH_VT: begin
					if (to) begin b.r[n[1:0]] = '{kind: KIND_END, ch: '0}; n = n + 3'd1; end
					to = 1'b0;
				end
				CH_SP, CH_TAB: begin
					if (so) begin
						b.r[n[1:0]] = '{kind: KIND_CHAR, ch: text.ch}; n = n + 3'd1;
						to = 1'b1;
					end else begin
						if (to) begin b.r[n[1:0]] = '{kind: KIND_END, ch: '0}; n = n + 3'd1; end
						to = 1'b0;
					end
				end
				CH_LP, CH_RP, CH_QUOTE: begin
					if (so) begin
						b.r[n[1:0]] = '{kind: KIND_CHAR, ch: text.ch}; n = n + 3'd1;
						to = 1'b1;
					end else begin
						if (to) begin b.r[n[1:0]] = '{kind: KIND_END, ch: '0}; n = n + 3'd1; end
						b.r[n[1:0]] = '{kind: KIND_CHAR, ch: text.ch}; n = n + 3'd1;
						b.r[n[1:0]] = '{kind: KIND_END, ch: '0}; n = n + 3'd1;
						to = 1'b0;
					end
				end
				CH_DQ: begin
					b.r[n[1:0]] = '{kind: KIND_CHAR, ch: text.ch}; n = n + 3'd1;
					to = 1'b1;
					so = !so;
				end
				CH_HASH: begin
					if (to) begin b.r[n[1:0]] = '{kind: KIND_END, ch: '0}; n = n + 3'd1; end
					to = 1'b0;
					ho = 1'b1;
				end
				CH_SEMI: begin
					if (to) begin b.r[n[1:0]] = '{kind: KIND_END, ch: '0}; n = n + 3'd1; end
					to = 1'b0;
					co = 1'b1;
				end
				default: begin
					b.r[n[1:0]] = '{kind: KIND_CHAR, ch: text.ch}; n = n + 3'd1;
					to = 1'b1;
				end
			endcase
		end
		b.last_idx = 2'(n - 3'd1);
	end

	assign text.ready = !full;
	assign accept     = text.valid && text.ready;
	assign push       = accept && (n != 3'd0);
	assign push_data  = b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			string_q  <= 1'b0;
			comment_q <= 1'b0;
			open_q    <= 1'b0;
			hash_q    <= 1'b0;
		end else if (accept) begin
			string_q  <= so;
			comment_q <= co;
			open_q    <= to;
			hash_q    <= ho;
		end
	end

endmodule

// ===== design/sts_fifo.sv =====
// sts_fifo: short queue of result bundles between the front and back parts.
// Depends on sts_pkg.

module sts_fifo import sts_pkg::*; #(
	parameter int DEPTH = STS_FIFO_DEPTH
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr_en,
	input  bundle_t wr_data,
	output logic    full,
	input  logic    rd_en,
	output bundle_t rd_data,
	output logic    empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	bundle_t        mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  cnt_q;
	logic           do_wr, do_rd;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/sts_back.sv =====
// sts_back: takes bundles from the queue and hands out their results one per
// cycle on the token channel while it is ready. Depends on sts_pkg, sts_if.

module sts_back import sts_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  bundle_t      rd_data,
	input  logic         empty,
	output logic         rd_en,
	sts_token_if.source  token
);

	bundle_t    cur_q;
	logic [1:0] idx_q;
	logic       busy_q;
	logic       fire, last, load;
	res_t       r;

	assign r     = cur_q.r[idx_q];
	assign fire  = busy_q && token.ready;
	assign last  = (idx_q == cur_q.last_idx);
	assign load  = !empty && (!busy_q || (fire && last));
	assign rd_en = load;

	assign token.valid       = busy_q;
	assign token.kind        = r.kind;
	assign token.out_char    = r.ch;
	assign token.last_of_run = last;

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= rd_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (fire) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

endmodule

// ===== design/sexpr_token_splitter.sv =====
// sexpr_token_splitter: top level of the S-expression token splitter.
// Depends on sts_pkg, sts_if, sts_front, sts_fifo, sts_back.
//
// Takes one text byte per cycle on the text channel and gives token results
// (character, end of token, newline, true literal) one per cycle on the token
// channel while it is ready. A byte gives zero to four results; its whole
// result group is queued in a FIFO of FIFO_DEPTH entries and then held in the
// back's bundle register, from which the first result shows. Bytes with at most
// one result stream at one per cycle; a byte with several results occupies the
// output until all are handed out, and the text channel stalls only while the
// FIFO is full. The output serializer, one result per cycle, sets the sustained rate.

module sexpr_token_splitter import sts_pkg::*; #(
	parameter int FIFO_DEPTH = STS_FIFO_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	sts_text_if.sink    text,
	sts_token_if.source token
);

	logic    push, full, pop, empty;
	bundle_t push_data, pop_data;

	sts_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.text      (text),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	sts_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (push_data),
		.full    (full),
		.rd_en   (pop),
		.rd_data (pop_data),
		.empty   (empty)
	);

	sts_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_data (pop_data),
		.empty   (empty),
		.rd_en   (pop),
		.token   (token)
	);

endmodule

// ===== verif/sts_split_check.sv =====
// sts_split_check: watches the text and token channels of the S-expression token splitter,
// predicts the token results of each accepted byte and compares them in order.
// Depends on sts_pkg and sts_if; hands a failure count and the outstanding count upward.

module sts_split_check import sts_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	sts_text_if  text,
	sts_token_if token,
	output int   fail_count,
	output int   pending
);

	typedef struct packed {
		kind_t      kind;
		logic [7:0] ch;
		logic       last;
	} token_res_t;

	logic       in_string = 1'b0;
	logic       in_comment = 1'b0;
	logic       tok_open = 1'b0;
	logic       hash_held = 1'b0;
	token_res_t run_buf[$];
	token_res_t expected_tokens[$];
	int         fails = 0;
	int         outstanding = 0;

	assign fail_count = fails;
	assign pending    = outstanding;

	function automatic void put_result(kind_t k, logic [7:0] c);
		token_res_t r;
		r.kind = k;
		r.ch   = (k == KIND_CHAR) ? c : 8'h00;
		r.last = 1'b0;
		run_buf.push_back(r);
	endfunction

	function automatic void close_token();
		if (tok_open) begin
			put_result(KIND_END, 8'h00);
			tok_open = 1'b0;
		end
	endfunction

	function automatic void append_char(logic [7:0] c);
		put_result(KIND_CHAR, c);
		tok_open = 1'b1;
	endfunction

	function automatic void lone_token(logic [7:0] c);
		close_token();
		append_char(c);
		close_token();
	endfunction

	function automatic void split_byte(logic [7:0] c, logic eot);
		run_buf = {};
		if (eot) begin
			if (hash_held)
				lone_token(CH_HASH);
			close_token();
			in_string  = 1'b0;
			in_comment = 1'b0;
			tok_open   = 1'b0;
			hash_held  = 1'b0;
		end else if (in_comment) begin
			if (c == CH_NL) begin
				put_result(KIND_NEWLINE, 8'h00);
				in_comment = 1'b0;
			end else if (c == CH_NUL || c == CH_FF8) begin
				in_comment = 1'b0;
			end
		end else if (hash_held && c == CH_T) begin
			hash_held = 1'b0;
			put_result(KIND_TRUE, 8'h00);
		end else begin
			if (hash_held) begin
				hash_held = 1'b0;
				lone_token(CH_HASH);
			end
			case (c)
				CH_NL: begin
					close_token();
					put_result(KIND_NEWLINE, 8'h00);
				end
				CH_CR, CH_FF, CH_VT: close_token();
				CH_SP, CH_TAB: begin
					if (in_string)
						append_char(c);
					else
						close_token();
				end
				CH_LP, CH_RP, CH_QUOTE: begin
					if (in_string)
						append_char(c);
					else
						lone_token(c);
				end
				CH_DQ: begin
					append_char(c);
					in_string = !in_string;
				end
				CH_HASH: begin
					close_token();
					hash_held = 1'b1;
				end
				CH_SEMI: begin
					close_token();
					in_comment = 1'b1;
				end
				default: append_char(c);
			endcase
		end
		if (run_buf.size() > 0)
			run_buf[run_buf.size()-1].last = 1'b1;
		foreach (run_buf[i])
			expected_tokens.push_back(run_buf[i]);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		token_res_t want;
		if (!arst_n) begin
			in_string       = 1'b0;
			in_comment      = 1'b0;
			tok_open        = 1'b0;
			hash_held       = 1'b0;
			expected_tokens = {};
			outstanding     = 0;
		end else begin
			if (token.valid && token.ready) begin
				if (expected_tokens.size() == 0) begin
					$error("unexpected result: kind %0d out_char %02h last_of_run %0b",
						token.kind, token.out_char, token.last_of_run);
					fails++;
				end else begin
					want = expected_tokens.pop_front();
					if (token.kind !== want.kind) begin
						$error("kind: expected %0d, actual %0d", want.kind, token.kind);
						fails++;
					end
					if (token.out_char !== want.ch) begin
						$error("out_char: expected %02h, actual %02h", want.ch, token.out_char);
						fails++;
					end
					if (token.last_of_run !== want.last) begin
						$error("last_of_run: expected %0b, actual %0b", want.last,
							token.last_of_run);
						fails++;
					end
				end
			end
			if (text.valid && text.ready)
				split_byte(text.ch, text.end_of_text);
			outstanding = expected_tokens.size();
		end
	end

endmodule

// ===== verif/sexpr_token_splitter_tb.sv =====
// sexpr_token_splitter_tb: drives text bytes into the token splitter with random gaps and
// back-pressure, and gives the verdict from the count kept by sts_split_check.
// Depends on sts_pkg, sts_if, sexpr_token_splitter and sts_split_check.

module sexpr_token_splitter_tb import sts_pkg::*;;

	localparam logic [7:0] SPACING [6] = '{CH_SP, CH_TAB, CH_NL, CH_CR, CH_FF, CH_VT};
	localparam logic [7:0] SINGLES [3] = '{CH_LP, CH_RP, CH_QUOTE};
	localparam logic [7:0] ENDERS  [3] = '{CH_NL, CH_NUL, CH_FF8};
	localparam logic [8:0] OPENING [26] = '{
		{1'b0, "a"}, {1'b0, CH_FF8}, {1'b0, CH_NUL}, {1'b0, CH_SP}, {1'b0, CH_LP},
		{1'b0, CH_DQ}, {1'b0, CH_SP}, {1'b0, CH_RP}, {1'b0, CH_TAB}, {1'b0, CH_DQ},
		{1'b0, CH_CR}, {1'b0, CH_HASH}, {1'b0, CH_T}, {1'b0, CH_HASH}, {1'b0, CH_QUOTE},
		{1'b0, CH_SEMI}, {1'b0, "x"}, {1'b0, CH_NL}, {1'b0, CH_SEMI}, {1'b0, CH_FF8},
		{1'b0, CH_SEMI}, {1'b0, CH_NUL}, {1'b0, "b"}, {1'b0, CH_HASH},
		{1'b1, 8'hA5}, {1'b1, 8'h00}
	};

	logic clk = 1'b0;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   sent_items = 0;
	logic tx_idle = 1'b1;

	sts_text_if  text_ch ();
	sts_token_if token_ch ();

	sexpr_token_splitter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.token  (token_ch)
	);

	sts_split_check token_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.text       (text_ch),
		.token      (token_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #5 clk = ~clk;

	function automatic logic [7:0] atom_char();
		logic [7:0] c;
		do begin
			if ($urandom_range(0, 3) == 0)
				c = 8'($urandom_range(0, 255));
			else
				c = 8'($urandom_range(33, 126));
		end while (c inside {CH_DQ, CH_HASH, CH_QUOTE, CH_LP, CH_RP, CH_SEMI,
			CH_NL, CH_CR, CH_FF, CH_VT, CH_SP, CH_TAB});
		return c;
	endfunction

	function automatic logic [7:0] string_char();
		if ($urandom_range(0, 2) == 0)
			return ($urandom_range(0, 1) == 0) ? SPACING[$urandom_range(0, 1)]
				: SINGLES[$urandom_range(0, 2)];
		return atom_char();
	endfunction

	function automatic logic [7:0] after_hash();
		case ($urandom_range(0, 7))
			0: return CH_LP;
			1: return CH_HASH;
			2: return CH_SEMI;
			3: return CH_DQ;
			4: return SPACING[$urandom_range(0, 5)];
			5: return CH_QUOTE;
			default: return atom_char();
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] c, input logic eot);
		int gap;
		if ($urandom_range(0, 29) == 0)
			tx_idle = !tx_idle;
		gap = tx_idle ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			text_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		text_ch.valid       <= 1'b1;
		text_ch.ch          <= c;
		text_ch.end_of_text <= eot;
		do @(posedge clk); while (!text_ch.ready);
		sent_items++;
	endtask

	task automatic wait_drained();
		text_ch.valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);
	endtask

	initial begin
		logic [7:0] c;
		int         n;
		arst_n              <= 1'b0;
		text_ch.valid       <= 1'b0;
		text_ch.ch          <= 8'h00;
		text_ch.end_of_text <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (OPENING[i])
			send_byte(OPENING[i][7:0], OPENING[i][8]);
		wait_drained();

		while (sent_items < 480) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4: begin
					n = $urandom_range(1, 6);
					repeat (n) send_byte(atom_char(), 1'b0);
				end
				5, 6, 7: send_byte(SPACING[$urandom_range(0, 5)], 1'b0);
				8, 9, 10: send_byte(SINGLES[$urandom_range(0, 2)], 1'b0);
				11, 12: begin
					send_byte(CH_DQ, 1'b0);
					n = $urandom_range(0, 6);
					repeat (n) send_byte(string_char(), 1'b0);
					send_byte(CH_DQ, 1'b0);
				end
				13, 14: begin
					send_byte(CH_HASH, 1'b0);
					send_byte(($urandom_range(0, 1) == 0) ? CH_T : after_hash(), 1'b0);
				end
				15: begin
					send_byte(CH_SEMI, 1'b0);
					n = $urandom_range(0, 5);
					repeat (n) begin
						do c = 8'($urandom_range(0, 255)); while (c inside {ENDERS});
						send_byte(c, 1'b0);
					end
					send_byte(ENDERS[$urandom_range(0, 2)], 1'b0);
				end
				16: send_byte(8'($urandom_range(0, 255)), 1'b1);
				17, 18: send_byte(8'($urandom_range(0, 255)), 1'b0);
				default: begin
					if ($urandom_range(0, 3) == 0)
						wait_drained();
					else
						send_byte(8'($urandom_range(0, 255)), 1'b0);
				end
			endcase
		end

		wait_drained();
		repeat (24) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		int   stall;
		logic rx_idle;
		rx_idle = 1'b1;
		token_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 29) == 0)
				rx_idle = !rx_idle;
			stall = rx_idle ? $urandom_range(0, 19) : 0;
			if (stall > 0) begin
				token_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			token_ch.ready <= 1'b1;
			do @(posedge clk); while (!token_ch.valid);
		end
	end

	initial begin
		#4000000;
		$display("FAILURE");
		$finish;
	end

endmodule

// ===== sexpr_token_splitter.f =====
design/sts_pkg.sv
design/sts_if.sv
design/sts_front.sv
design/sts_fifo.sv
design/sts_back.sv
design/sexpr_token_splitter.sv
verif/sts_split_check.sv
verif/sexpr_token_splitter_tb.sv
